// ===== src/ptp_pkg.sv =====
package ptp_pkg;

    localparam int COORD_W      = 32;
    localparam int NUM_REGS     = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 6;
    localparam int REG_IDX_W    = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int RECIP_W      = 63;
    localparam int RECIP_SHIFT  = 62;

    localparam logic [REG_IDX_W-1:0] REG_ROW1_C12 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_C34 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_C12 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_C34 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_C12 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_C34 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW4_C12 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW4_C34 = 3'd7;

endpackage

// ===== src/point_transform_perspective_unit.sv =====
// Stages: 3 transform stages, 63 reciprocal stages at one quotient bit
// each, 3 scale/saturate stages.
// Throughput: one point per cycle; the whole pipe advances while the output
// register is empty or being taken.
// Reset: synchronous, active low; clears valid bits and loads the matrix
// with the identity.
module point_transform_perspective_unit #(
    parameter int FRAC_BITS = ptp_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ptp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [ptp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [ptp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata,  // in_x, in_y, in_z
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [95:0]                   m_axis_tdata,  // out_x, out_y, out_z
    output logic [1:0]                    m_axis_tuser   // w_is_zero, overflowed
);
    import ptp_pkg::*;

    localparam int PF_W  = 2 * COORD_W - FRAC_BITS;   // floored product
    localparam int SW    = PF_W + 2;                  // row sum
    localparam int MW    = SW;                        // magnitude
    localparam int PW    = MW + RECIP_W;              // full scaled product
    localparam int SH    = RECIP_SHIFT - FRAC_BITS;
    localparam int NDIV  = RECIP_W;
    localparam logic [CFG_DATA_W-1:0] ONE_LO = CFG_DATA_W'(1) << FRAC_BITS;
    localparam logic [CFG_DATA_W-1:0] ONE_HI = CFG_DATA_W'(1) << (FRAC_BITS + COORD_W);

    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         neg;
        logic               wz;
    } t_item;

    // configuration
    logic [CFG_DATA_W-1:0] r_cfg [NUM_REGS];
    logic                  cfg_we;
    logic [REG_IDX_W-1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W];
    assign cfg_we  = psel && penable && pwrite;
    assign prdata  = r_cfg[cfg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_ROW1_C12] <= ONE_LO;
            r_cfg[REG_ROW1_C34] <= '0;
            r_cfg[REG_ROW2_C12] <= ONE_HI;
            r_cfg[REG_ROW2_C34] <= '0;
            r_cfg[REG_ROW3_C12] <= '0;
            r_cfg[REG_ROW3_C34] <= ONE_LO;
            r_cfg[REG_ROW4_C12] <= '0;
            r_cfg[REG_ROW4_C34] <= ONE_HI;
        end else if (cfg_we) begin
            r_cfg[cfg_idx] <= pwdata;
        end
    end

    logic signed [COORD_W-1:0] m [4][4];
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                m[r][c] = r_cfg[r*2 + c/2][(c%2)*COORD_W +: COORD_W];
            end
        end
    end

    // pipeline control
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: products, floored
    logic signed [COORD_W-1:0] in_c [3];
    logic signed [PF_W-1:0]    r_pf [4][3];
    logic                      r_v1;
    logic signed [COORD_W-1:0] r_t4 [4];
    assign in_c[0] = s_axis_tdata[31:0];
    assign in_c[1] = s_axis_tdata[63:32];
    assign in_c[2] = s_axis_tdata[95:64];

    always_ff @(posedge i_clk) begin
        logic signed [2*COORD_W-1:0] p;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
        end
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    p = in_c[i] * m[i][j];
                    r_pf[j][i] <= p[2*COORD_W-1:FRAC_BITS];
                end
                r_t4[j] <= m[3][j];
            end
        end
    end

    // stage 2: row sums
    logic signed [SW-1:0] r_v [4];
    logic                 r_v2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                r_v[j] <= SW'(r_pf[j][0]) + SW'(r_pf[j][1]) + SW'(r_pf[j][2])
                        + SW'(r_t4[j]);
            end
        end
    end

    // stage 3: magnitudes, signs; reciprocal pipe input
    t_item           r_it  [NDIV+1];
    logic [MW-1:0]   r_d   [NDIV];
    logic [MW-1:0]   r_rem [NDIV];
    logic [RECIP_W-1:0] r_q [NDIV+1];
    logic            r_dv  [NDIV+1];

    // reciprocal: restoring division of 2^62 by |W|, one bit per stage
    always_ff @(posedge i_clk) begin
        logic [MW-1:0] wm;
        logic [MW:0]   t;
        logic          ge;
        wm = r_v[3][SW-1] ? MW'(-r_v[3]) : MW'(r_v[3]);
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_v2;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_it[0].mag[j] <= r_v[j][SW-1] ? MW'(-r_v[j]) : MW'(r_v[j]);
                r_it[0].neg[j] <= r_v[j][SW-1] ^ r_v[3][SW-1];
            end
            r_it[0].wz <= (r_v[3] == '0);
            r_d[0]     <= wm;
            r_rem[0]   <= '0;
            r_q[0]     <= '0;
        end
        for (int k = 0; k < NDIV; k++) begin
            if (!i_rst_n) begin
                r_dv[k+1] <= 1'b0;
            end else if (en) begin
                r_dv[k+1] <= r_dv[k];
            end
            t  = {r_rem[k], (k == 0)};
            ge = (t >= {1'b0, r_d[k]});
            if (en) begin
                if (k < NDIV - 1) begin
                    r_rem[k+1] <= ge ? MW'(t - {1'b0, r_d[k]}) : MW'(t);
                    r_d[k+1]   <= r_d[k];
                end
                r_q[k+1]   <= {r_q[k][RECIP_W-2:0], ge};
                r_it[k+1]  <= r_it[k];
            end
        end
    end

    // scale stage 1: partial products
    logic [63:0]              r_pp00 [3];
    logic [62:0]              r_pp01 [3];
    logic [MW-1:0]            r_pp10 [3];
    logic [MW-2:0]            r_pp11 [3];
    t_item                    r_it_m1;
    logic                     r_vm1;
    always_ff @(posedge i_clk) begin
        logic [31:0]    c0;
        logic [MW-33:0] c1;
        logic [31:0]    q0;
        logic [30:0]    q1;
        q0 = r_q[NDIV][31:0];
        q1 = r_q[NDIV][RECIP_W-1:32];
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
        end else if (en) begin
            r_vm1 <= r_dv[NDIV];
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                c0 = r_it[NDIV].mag[j][31:0];
                c1 = r_it[NDIV].mag[j][MW-1:32];
                r_pp00[j] <= 64'(c0) * 64'(q0);
                r_pp01[j] <= 63'(c0) * 63'(q1);
                r_pp10[j] <= MW'(c1) * MW'(q0);
                r_pp11[j] <= (MW-1)'(c1) * (MW-1)'(q1);
            end
            r_it_m1 <= r_it[NDIV];
        end
    end

    // scale stage 2: full product
    logic [PW-1:0] r_prod [3];
    t_item         r_it_m2;
    logic          r_vm2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm2 <= 1'b0;
        end else if (en) begin
            r_vm2 <= r_vm1;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[j] <= PW'(r_pp00[j])
                           + (PW'(r_pp01[j]) << 32)
                           + (PW'(r_pp10[j]) << 32)
                           + (PW'(r_pp11[j]) << 64);
            end
            r_it_m2 <= r_it_m1;
        end
    end

    // scale stage 3: shift, saturate, sign; output register
    logic [95:0] r_odata;
    logic [1:0]  r_ouser;
    logic        r_ovld;
    always_ff @(posedge i_clk) begin
        logic [31:0] q;
        logic [31:0] lim;
        logic        ov;
        logic        big;
        ov = 1'b0;
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (en) begin
            r_ovld <= r_vm2;
        end
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                q   = r_prod[j][SH +: 32];
                lim = r_it_m2.neg[j] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                big = (|r_prod[j][PW-1:SH+32]) || (q > lim);
                if (big) begin
                    q  = lim;
                    ov = 1'b1;
                end
                if (r_it_m2.wz) begin
                    r_odata[j*32 +: 32] <= '0;
                end else begin
                    r_odata[j*32 +: 32] <= r_it_m2.neg[j] ? -q : q;
                end
            end
            r_ouser <= {ov && !r_it_m2.wz, r_it_m2.wz};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

`ifndef SYNTH
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output stage");
    a_wz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
        else $error("zero w result not cleared");
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule
